>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the character LCD sequencer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LCDNS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("lcd sequencer assertion failed");

// antecedent implies consequent on the next clock edge
`define LCDNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lcd sequencer assertion failed");

`endif

>>> rtl/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, constants and microcode program of the LCD nibble sequencer
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // item operations
  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_INIT   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_LINES = 2'd0,
    CFG_COLUMNS   = 2'd1,
    CFG_TALL_FONT = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  // nibble source of a step
  typedef enum logic [1:0] {
    NIB_CONST   = 2'd0,
    NIB_BYTE_HI = 2'd1,
    NIB_BYTE_LO = 2'd2,
    NIB_FSET_LO = 2'd3
  } nib_sel_e;

  // settle time of a step
  typedef enum logic [1:0] {
    WAIT_STROBE = 2'd0,
    WAIT_LONG   = 2'd1,
    WAIT_MID    = 2'd2,
    WAIT_CLEAR  = 2'd3
  } wait_sel_e;

  localparam int unsigned BEFORE_W = 16;
  localparam int unsigned AFTER_W  = 13;
  localparam int unsigned UPC_W    = 4;

  localparam logic [BEFORE_W-1:0] POWERUP_US = 16'd50000;
  localparam logic [AFTER_W-1:0]  STROBE_US  = 13'd100;
  localparam logic [AFTER_W-1:0]  LONG_US    = 13'd4600;
  localparam logic [AFTER_W-1:0]  MID_US     = 13'd250;
  localparam logic [AFTER_W-1:0]  CLEAR_US   = 13'd2100;

  localparam logic [7:0] CMD_CLEAR = 8'h01;

  // program entry points
  localparam logic [UPC_W-1:0] UPC_BYTE = 4'd0;
  localparam logic [UPC_W-1:0] UPC_INIT = 4'd3;

  // one control word
  typedef struct packed {
    nib_sel_e         nib_sel;
    logic [3:0]       nib_const;
    logic             rs_item;
    logic             powerup;
    wait_sel_e        wait_sel;
    logic             jump_on_clear;
    logic [UPC_W-1:0] jump_target;
    logic             last;
  } uc_word_t;

  // microcode program
  function automatic uc_word_t uc_rom(logic [UPC_W-1:0] addr);
    uc_word_t w;
    w = '{nib_sel: NIB_CONST, nib_const: 4'h0, rs_item: 1'b0, powerup: 1'b0,
          wait_sel: WAIT_STROBE, jump_on_clear: 1'b0, jump_target: '0, last: 1'b0};
    unique case (addr)
      // byte send: high nibble, then low nibble with normal or clear settle
      4'd0: begin
        w.nib_sel       = NIB_BYTE_HI;
        w.rs_item       = 1'b1;
        w.jump_on_clear = 1'b1;
        w.jump_target   = 4'd2;
      end
      4'd1: begin
        w.nib_sel = NIB_BYTE_LO;
        w.rs_item = 1'b1;
        w.last    = 1'b1;
      end
      4'd2: begin
        w.nib_sel  = NIB_BYTE_LO;
        w.rs_item  = 1'b1;
        w.wait_sel = WAIT_CLEAR;
        w.last     = 1'b1;
      end
      // power-up: wake strobes
      4'd3: begin
        w.nib_const = 4'h3;
        w.powerup   = 1'b1;
        w.wait_sel  = WAIT_LONG;
      end
      4'd4: begin
        w.nib_const = 4'h3;
        w.wait_sel  = WAIT_LONG;
      end
      4'd5: begin
        w.nib_const = 4'h3;
        w.wait_sel  = WAIT_MID;
      end
      4'd6: w.nib_const = 4'h2;
      // function set
      4'd7: w.nib_const = 4'h2;
      4'd8: w.nib_sel = NIB_FSET_LO;
      // display on
      4'd9:  w.nib_const = 4'h0;
      4'd10: w.nib_const = 4'hC;
      // clear display
      4'd11: w.nib_const = 4'h0;
      4'd12: begin
        w.nib_const = 4'h1;
        w.wait_sel  = WAIT_CLEAR;
      end
      // entry mode
      4'd13: w.nib_const = 4'h0;
      4'd14: begin
        w.nib_const = 4'h6;
        w.last      = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/lcdns_cursor_addr.sv
// ----------------------------------------------------------------------------
// lcdns_cursor_addr
// Builds the set-address command byte from a column and a clamped row
// ----------------------------------------------------------------------------
module lcdns_cursor_addr #(
  parameter int unsigned ROW_SLOTS = 4
) (
  input  logic [6:0] column_i,
  input  logic [2:0] row_i,
  input  logic [2:0] num_lines_i,
  input  logic [5:0] columns_i,
  output logic [7:0] cmd_o
);

  localparam logic [2:0] RowMax = 3'(ROW_SLOTS - 1);

  logic [2:0] row_slot;
  logic [2:0] lines;
  logic [2:0] row_eff;
  logic [6:0] offset;
  logic [6:0] sum;

  // clamp to the row slots, then to the configured line count
  always_comb begin
    row_slot = (row_i > RowMax) ? RowMax : row_i;
    lines    = (num_lines_i == 3'd0) ? 3'd1 : num_lines_i;
    row_eff  = (row_slot >= lines) ? (lines - 3'd1) : row_slot;
  end

  // row start address
  always_comb begin
    case (row_eff[1:0])
      2'd0:    offset = 7'h00;
      2'd1:    offset = 7'h40;
      2'd2:    offset = {1'b0, columns_i};
      default: offset = 7'h40 + {1'b0, columns_i};
    endcase
  end

  // address wraps to 7 bits
  assign sum   = column_i + offset;
  assign cmd_o = {1'b1, sum};

endmodule

>>> rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character LCD 4-bit bus sequencer driven by a microcode program
// ----------------------------------------------------------------------------
// An accepted item loads the step counter, which feeds the output register.
// The microcode counter issues one strobe per cycle while the output is free.
// A new item is taken the cycle after the last strobe issues. Send and cursor items
// strobe two nibbles, initialization the power-up program, an unknown op nothing.
// Input stall stays high while the program runs, so items are handled one at a time.
// Reset clears the sequencer and output valid and loads the register defaults.
module char_lcd_nibble_sequencer #(
  parameter int unsigned ROW_SLOTS  = 4,
  parameter int unsigned DATA_LINES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic                  is_data_i,
  input  logic [7:0]            byte_value_i,
  input  logic [6:0]            column_i,
  input  logic [2:0]            row_i,
  // strobe channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  reg_select_o,
  output logic [DATA_LINES-1:0] nibble_o,
  output logic [15:0]           delay_before_us_o,
  output logic [12:0]           wait_after_us_o,
  output logic                  last_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [5:0]            cfg_data_i
);

  // configuration registers
  logic [2:0] num_lines_q;
  logic [5:0] columns_q;
  logic       tall_font_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_lines_q <= 3'd1;
      columns_q   <= 6'd16;
      tall_font_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (lcdns_pkg::cfg_idx_e'(cfg_index_i))
        lcdns_pkg::CFG_NUM_LINES: num_lines_q <= cfg_data_i[2:0];
        lcdns_pkg::CFG_COLUMNS:   columns_q   <= cfg_data_i;
        lcdns_pkg::CFG_TALL_FONT: tall_font_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // cursor command from the item fields
  logic [7:0] cursor_cmd;

  lcdns_cursor_addr #(
    .ROW_SLOTS(ROW_SLOTS)
  ) u_cursor (
    .column_i   (column_i),
    .row_i      (row_i),
    .num_lines_i(num_lines_q),
    .columns_i  (columns_q),
    .cmd_o      (cursor_cmd)
  );

  // sequencer state
  logic                         run_q, run_d;
  logic [lcdns_pkg::UPC_W-1:0]  upc_q, upc_d;
  logic                         rs_q, rs_d;
  logic [7:0]                   byte_q, byte_d;

  logic in_accept;
  logic out_free;
  logic issue;
  lcdns_pkg::uc_word_t uw;
  logic clear_cmd;

  assign in_stall_o = run_q;
  assign in_accept  = in_valid_i && !run_q;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign issue      = run_q && out_free;
  assign uw         = lcdns_pkg::uc_rom(upc_q);
  assign clear_cmd  = !rs_q && (byte_q == lcdns_pkg::CMD_CLEAR);

  // dispatch and step counter
  always_comb begin
    run_d  = run_q;
    upc_d  = upc_q;
    rs_d   = rs_q;
    byte_d = byte_q;
    if (in_accept) begin
      unique case (lcdns_pkg::op_e'(op_i))
        lcdns_pkg::OP_SEND: begin
          run_d  = 1'b1;
          upc_d  = lcdns_pkg::UPC_BYTE;
          rs_d   = is_data_i;
          byte_d = byte_value_i;
        end
        lcdns_pkg::OP_INIT: begin
          run_d  = 1'b1;
          upc_d  = lcdns_pkg::UPC_INIT;
          rs_d   = 1'b0;
        end
        lcdns_pkg::OP_CURSOR: begin
          run_d  = 1'b1;
          upc_d  = lcdns_pkg::UPC_BYTE;
          rs_d   = 1'b0;
          byte_d = cursor_cmd;
        end
        default: ;
      endcase
    end else if (issue) begin
      if (uw.last) begin
        run_d = 1'b0;
      end
      if (uw.jump_on_clear && clear_cmd) begin
        upc_d = uw.jump_target;
      end else begin
        upc_d = upc_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      upc_q <= '0;
    end else begin
      run_q <= run_d;
      upc_q <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q   <= rs_d;
    byte_q <= byte_d;
  end

  // datapath for the current step
  logic [3:0]  nib;
  logic [12:0] wait_us;

  always_comb begin
    unique case (uw.nib_sel)
      lcdns_pkg::NIB_BYTE_HI: nib = byte_q[7:4];
      lcdns_pkg::NIB_BYTE_LO: nib = byte_q[3:0];
      lcdns_pkg::NIB_FSET_LO: nib = {num_lines_q > 3'd1,
                                     tall_font_q && (num_lines_q == 3'd1), 2'b00};
      default:                nib = uw.nib_const;
    endcase
  end

  always_comb begin
    unique case (uw.wait_sel)
      lcdns_pkg::WAIT_LONG:  wait_us = lcdns_pkg::LONG_US;
      lcdns_pkg::WAIT_MID:   wait_us = lcdns_pkg::MID_US;
      lcdns_pkg::WAIT_CLEAR: wait_us = lcdns_pkg::CLEAR_US;
      default:               wait_us = lcdns_pkg::STROBE_US;
    endcase
  end

  // output register
  logic                  out_valid_q;
  logic                  rs_out_q;
  logic [DATA_LINES-1:0] nib_out_q;
  logic [15:0]           before_q;
  logic [12:0]           after_q;
  logic                  last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rs_out_q  <= uw.rs_item & rs_q;
      nib_out_q <= DATA_LINES'(nib);
      before_q  <= uw.powerup ? lcdns_pkg::POWERUP_US : '0;
      after_q   <= wait_us;
      last_q    <= uw.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign reg_select_o      = rs_out_q;
  assign nibble_o          = nib_out_q;
  assign delay_before_us_o = before_q;
  assign wait_after_us_o   = after_q;
  assign last_o            = last_q;

endmodule

>>> rtl/lcdns_checker.sv
// ----------------------------------------------------------------------------
// lcdns_checker
// Port-level checks of the LCD nibble sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  op_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        reg_select_o,
  input logic [3:0]  nibble_o,
  input logic [15:0] delay_before_us_o,
  input logic [12:0] wait_after_us_o,
  input logic        last_o
);

  // stalled strobe holds its nibble, settle time and last flag
  `LCDNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(nibble_o) && $stable(wait_after_us_o) && $stable(last_o))

  // a real operation keeps the input stalled while it runs
  `LCDNS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o && op_i != lcdns_pkg::OP_NONE, in_stall_o)

  // power-up delay only before a command 0x3 strobe
  `LCDNS_ASSERT(a_powerup_strobe, clk_i, rst_ni, !(out_valid_o && delay_before_us_o != 16'd0) || (!reg_select_o && nibble_o == 4'h3 && !last_o))

  // data strobes never carry the long settle times
  `LCDNS_ASSERT(a_data_wait, clk_i, rst_ni, !(out_valid_o && reg_select_o) || wait_after_us_o == lcdns_pkg::STROBE_US)

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .op_i             (op_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .reg_select_o     (reg_select_o),
  .nibble_o         (nibble_o),
  .delay_before_us_o(delay_before_us_o),
  .wait_after_us_o  (wait_after_us_o),
  .last_o           (last_o)
);

>>> bench/char_lcd_nibble_sequencer_check.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_check
// Watches the item, strobe and register channels of the LCD nibble sequencer,
// predicts the strobe train of every accepted item and compares each strobe
// field by field with the oldest prediction
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_check
  import lcdns_pkg::*;
#(
  parameter int unsigned ROW_SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic        is_data_i,
  input  logic [7:0]  byte_value_i,
  input  logic [6:0]  column_i,
  input  logic [2:0]  row_i,
  // strobe channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        reg_select_i,
  input  logic [3:0]  nibble_i,
  input  logic [15:0] delay_before_us_i,
  input  logic [12:0] wait_after_us_i,
  input  logic        last_i,
  // register writes
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  // status toward the stimulus
  output int unsigned fail_count_o,
  output int unsigned strobes_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // bus timing in microseconds
  localparam logic [15:0] POWER_ON_WAIT = 16'd50000;
  localparam logic [12:0] SETTLE_BASE   = 13'd100;
  localparam logic [12:0] SETTLE_WAKE   = 13'd4600;
  localparam logic [12:0] SETTLE_THIRD  = 13'd250;
  localparam logic [12:0] SETTLE_CLEAR  = 13'd2100;
  localparam logic [7:0]  CLEAR_BYTE    = 8'h01;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] before_us;
    logic [12:0] after_us;
    logic        last;
  } strobe_t;

  strobe_t     strobe_queue[$];
  logic [2:0]  lines_q;
  logic [5:0]  cols_q;
  logic        tall_q;
  int unsigned fails;

  function automatic void push_strobe(logic rs, logic [3:0] nib, logic [15:0] before_us,
                                      logic [12:0] after_us);
    strobe_t s;
    s.rs        = rs;
    s.nibble    = nib;
    s.before_us = before_us;
    s.after_us  = after_us;
    s.last      = 1'b0;
    strobe_queue.push_back(s);
  endfunction

  // one byte as two strobes, high nibble first, clear command settles longer
  function automatic void push_byte(logic rs, logic [7:0] b);
    logic [12:0] settle;
    settle = (!rs && b == CLEAR_BYTE) ? SETTLE_CLEAR : SETTLE_BASE;
    push_strobe(rs, b[7:4], 16'd0, SETTLE_BASE);
    push_strobe(rs, b[3:0], 16'd0, settle);
  endfunction

  // strobe train of one item under the current register values
  function automatic void predict_strobes(logic [1:0] op, logic isd, logic [7:0] b,
                                          logic [6:0] col, logic [2:0] row);
    logic [7:0] fset;
    logic [2:0] eff_lines;
    logic [2:0] r;
    logic [7:0] offset;
    logic [7:0] addr;
    strobe_t    tail;
    case (op_e'(op))
      OP_SEND: push_byte(isd, b);
      OP_INIT: begin
        fset = 8'h20;
        if (lines_q > 3'd1) fset = fset | 8'h08;
        if (tall_q && lines_q == 3'd1) fset = fset | 8'h04;
        push_strobe(1'b0, 4'h3, POWER_ON_WAIT, SETTLE_WAKE);
        push_strobe(1'b0, 4'h3, 16'd0, SETTLE_WAKE);
        push_strobe(1'b0, 4'h3, 16'd0, SETTLE_THIRD);
        push_strobe(1'b0, 4'h2, 16'd0, SETTLE_BASE);
        push_byte(1'b0, fset);
        push_byte(1'b0, 8'h0C);
        push_byte(1'b0, CLEAR_BYTE);
        push_byte(1'b0, 8'h06);
      end
      OP_CURSOR: begin
        eff_lines = (lines_q == 3'd0) ? 3'd1 : lines_q;
        r = row;
        if (r >= ROW_SLOTS) r = 3'(ROW_SLOTS - 1);
        if (r >= eff_lines) r = eff_lines - 3'd1;
        case (r[1:0])
          2'd0:    offset = 8'h00;
          2'd1:    offset = 8'h40;
          2'd2:    offset = {2'b00, cols_q};
          default: offset = 8'h40 + {2'b00, cols_q};
        endcase
        addr = {1'b0, col} + offset;
        push_byte(1'b0, {1'b1, addr[6:0]});
      end
      default: ;
    endcase
    // mark the final strobe of the item
    if (op_e'(op) != OP_NONE) begin
      tail = strobe_queue.pop_back();
      tail.last = 1'b1;
      strobe_queue.push_back(tail);
    end
  endfunction

  function automatic int unsigned field_miss(string name, int unsigned want,
                                             int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  // sample every channel at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    strobe_t want;
    if (!rst_ni) begin
      strobe_queue.delete();
      lines_q       = 3'd1;
      cols_q        = 6'd16;
      tall_q        = 1'b0;
      fails         = 0;
      fail_count_o  <= 0;
      strobes_due_o <= 0;
    end else begin
      // strobe transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (strobe_queue.size() == 0) begin
          $display("%0t: unexpected strobe, expected none, actual rs %0d nibble %0h",
                   $time, reg_select_i, nibble_i);
          fails++;
        end else begin
          want = strobe_queue.pop_front();
          fails += field_miss("reg_select", want.rs, reg_select_i);
          fails += field_miss("nibble", want.nibble, nibble_i);
          fails += field_miss("delay_before_us", want.before_us, delay_before_us_i);
          fails += field_miss("wait_after_us", want.after_us, wait_after_us_i);
          fails += field_miss("last", want.last, last_i);
        end
      end
      // item transaction
      if (in_valid_i && !in_stall_i)
        predict_strobes(op_i, is_data_i, byte_value_i, column_i, row_i);
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NUM_LINES: lines_q = cfg_data_i[2:0];
          CFG_COLUMNS:   cols_q  = cfg_data_i;
          CFG_TALL_FONT: tall_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      fail_count_o  <= fails;
      strobes_due_o <= strobe_queue.size();
    end
  end

endmodule

>>> bench/char_lcd_nibble_sequencer_test.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_test
// Stimulus and verdict for the LCD nibble sequencer: directed items over the
// field extremes and register corners, then random phases under several
// register settings with bursty input and a patterned output stall
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_test import lcdns_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 5;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int TIMEOUT_NS      = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic        is_data_i;
  logic [7:0]  byte_value_i;
  logic [6:0]  column_i;
  logic [2:0]  row_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        reg_select_o;
  logic [3:0]  nibble_o;
  logic [15:0] delay_before_us_o;
  logic [12:0] wait_after_us_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [5:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned strobes_due;
  int          burst_left;
  bit          gaps_on;
  int          holds_asked;
  int          holds_done;

  char_lcd_nibble_sequencer #(
    .ROW_SLOTS (4),
    .DATA_LINES(4)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .is_data_i        (is_data_i),
    .byte_value_i     (byte_value_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_select_o     (reg_select_o),
    .nibble_o         (nibble_o),
    .delay_before_us_o(delay_before_us_o),
    .wait_after_us_o  (wait_after_us_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  char_lcd_nibble_sequencer_check #(
    .ROW_SLOTS(4)
  ) checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .is_data_i        (is_data_i),
    .byte_value_i     (byte_value_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_select_i     (reg_select_o),
    .nibble_i         (nibble_o),
    .delay_before_us_i(delay_before_us_o),
    .wait_after_us_i  (wait_after_us_o),
    .last_i           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .strobes_due_o    (strobes_due)
  );

  // clock
  always #(CLK_HALF) clk_i = ~clk_i;

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL char_lcd_nibble_sequencer");
    $finish;
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin : recv_pattern
    int mode;
    int mode_left;
    mode        = 0;
    mode_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_asked) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       out_stall_i = 1'b0;
          1:       out_stall_i = ($urandom_range(0, 3) == 0);
          2:       out_stall_i = ($urandom_range(0, 9) < 7);
          default: out_stall_i = ~out_stall_i;
        endcase
      end
    end
  end

  // one item transaction, preceded by a gap when gaps are on and a burst has run out
  task automatic offer_item(op_e op, logic isd, logic [7:0] b, logic [6:0] col,
                            logic [2:0] row);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i   = 1'b0;
      op_i         = 2'($urandom);
      byte_value_i = 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    op_i         = op;
    is_data_i    = isd;
    byte_value_i = b;
    column_i     = col;
    row_i        = row;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and let every predicted strobe drain out
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (strobes_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // register write transaction
  task automatic cfg_write(cfg_idx_e idx, logic [5:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(logic [5:0] lines, logic [5:0] cols, logic tall);
    settle_block();
    cfg_write(CFG_NUM_LINES, lines);
    cfg_write(CFG_COLUMNS, cols);
    cfg_write(CFG_TALL_FONT, {5'($urandom), tall});
  endtask

  // random item, unused fields left random
  task automatic random_item();
    int         pick;
    logic       isd;
    logic [7:0] b;
    logic [6:0] col;
    logic [2:0] row;
    op_e        op;
    pick = $urandom_range(0, 99);
    isd  = 1'($urandom);
    b    = 8'($urandom);
    col  = 7'($urandom);
    row  = 3'($urandom);
    if (pick < 45) begin
      op = OP_SEND;
      if ($urandom_range(0, 9) == 0) begin
        isd = 1'b0;
        b   = 8'h01;
      end
    end else if (pick < 57) begin
      op = OP_INIT;
    end else if (pick < 95) begin
      op = OP_CURSOR;
      if ($urandom_range(0, 3) != 0) col = 7'($urandom_range(0, 79));
    end else begin
      op = OP_NONE;
    end
    offer_item(op, isd, b, col, row);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [5:0] lines;
    logic [5:0] cols;
    logic       tall;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OP_SEND;
    is_data_i    = 1'b0;
    byte_value_i = 8'h00;
    column_i     = 7'd0;
    row_i        = 3'd0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_NUM_LINES;
    cfg_data_i   = 6'd0;
    burst_left   = 0;
    gaps_on      = 1'b0;
    holds_asked  = 0;
    holds_done   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset registers, byte extremes, clear, every op
    offer_item(OP_SEND, 1'b0, 8'h00, 7'd0, 3'd0);
    offer_item(OP_SEND, 1'b1, 8'hFF, 7'd0, 3'd0);
    offer_item(OP_SEND, 1'b0, 8'h01, 7'd0, 3'd0);
    offer_item(OP_SEND, 1'b1, 8'h01, 7'd0, 3'd0);
    offer_item(OP_SEND, 1'b0, 8'h80, 7'd0, 3'd0);
    offer_item(OP_INIT, 1'b0, 8'h00, 7'd0, 3'd0);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd127, 3'd7);
    offer_item(OP_NONE, 1'b1, 8'hFF, 7'd127, 3'd7);
    // tall font with one line
    set_config(6'd1, 6'd16, 1'b1);
    offer_item(OP_INIT, 1'b0, 8'h00, 7'd0, 3'd0);
    // four lines of forty: every row, row clamp above three
    set_config(6'd4, 6'd40, 1'b1);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd0, 3'd0);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd5, 3'd1);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd79, 3'd2);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd127, 3'd3);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd39, 3'd4);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd10, 3'd5);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd64, 3'd6);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd1, 3'd7);
    offer_item(OP_INIT, 1'b0, 8'h00, 7'd0, 3'd0);
    // write to the spare index leaves the registers alone
    settle_block();
    cfg_write(CFG_UNUSED, 6'h3F);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd3, 3'd3);
    // zero lines acts as one line, no tall font
    set_config(6'd0, 6'd63, 1'b0);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd20, 3'd6);
    offer_item(OP_INIT, 1'b0, 8'h00, 7'd0, 3'd0);
    // address wrap and zero columns
    set_config(6'd2, 6'd0, 1'b0);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd127, 3'd1);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd9, 3'd3);
    set_config(6'd3, 6'd0, 1'b0);
    offer_item(OP_CURSOR, 1'b0, 8'h00, 7'd100, 3'd2);

    // random phases, register extremes first
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin lines = 6'd1; cols = 6'd1;  tall = 1'b0; end
        1: begin lines = 6'd4; cols = 6'd40; tall = 1'b1; end
        2: begin lines = 6'h3F; cols = 6'd63; tall = 1'b1; end
        default: begin
          lines = 6'($urandom);
          case ($urandom_range(0, 5))
            0:       cols = 6'd0;
            1:       cols = 6'd63;
            2:       cols = 6'd40;
            default: cols = 6'($urandom_range(1, 40));
          endcase
          tall = 1'($urandom);
        end
      endcase
      set_config(lines, cols, tall);
      gaps_on = (phase != 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // receiver holds off while items keep coming
        if (phase == 1 && n == 10) holds_asked++;
        // sender waits for the pipe to run dry
        if (phase == 2 && n == 30) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          while (strobes_due != 0) @(negedge clk_i);
        end
        random_item();
      end
    end

    settle_block();
    if (fail_count == 0 && strobes_due == 0) begin
      $display("PASS char_lcd_nibble_sequencer");
    end else begin
      $display("FAIL char_lcd_nibble_sequencer");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lcdns_pkg.sv
rtl/lcdns_cursor_addr.sv
rtl/char_lcd_nibble_sequencer.sv
rtl/lcdns_checker.sv
bench/char_lcd_nibble_sequencer_check.sv
bench/char_lcd_nibble_sequencer_test.sv
